>>> rtl/sliding_window_median_unit_macros.svh
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

>>> rtl/swm_pkg.sv
// Package with sizes, types and constants of the sliding window median unit.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 7;
  localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);

  typedef logic [SAMPLE_BITS-1:0] key_t;
  typedef logic [IDX_BITS-1:0]    age_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [CFG_BITS-1:0]    cfg_t;

  // Flipping the sign bit makes unsigned compare follow signed order.
  localparam key_t SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Link between neighboring cells.
  typedef struct packed {
    key_t key;
    age_t age;
    logic le;
  } cell_link_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic upd;
    logic ev;
    key_t key_new;
    key_t key_old;
    age_t age_lim;
  } cell_ctl_t;

endpackage

>>> rtl/swm_in_if.sv
// Input channel interface: valid/ready with sample and start flag.
`timescale 1ns / 1ps
interface swm_in_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

>>> rtl/swm_out_if.sv
// Result channel interface: valid/ready with the median.
`timescale 1ns / 1ps
interface swm_out_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

>>> rtl/swm_cell.sv
// One cell of the sorted window row: holds one key and its age.
`timescale 1ns / 1ps
module swm_cell import swm_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       valid,
  input  logic       bvalid,
  input  logic       sel,
  input  cell_link_t from_hi,
  input  cell_link_t from_lo,
  output cell_link_t to_lo,
  output cell_link_t to_hi,
  output logic       match,
  output key_t       old_key,
  output key_t       mid_key
);

  key_t       key_r, key_nxt;
  age_t       age_r, age_nxt;
  logic       le;
  logic       below_old;
  cell_link_t b;

  always_comb begin
    le = (key_r <= ctl.key_new);
    // Equal keys sit oldest first, so the first equal entry is the evicted one.
    below_old = !ctl.ev || (key_r < ctl.key_old);
    to_lo = '{key: key_r, age: age_r, le: le};
    // Row with the evicted entry taken out.
    b.key = below_old ? key_r : from_hi.key;
    b.age = below_old ? age_r : from_hi.age;
    b.le  = bvalid && (below_old ? le : from_hi.le);
    to_hi = b;
  end

  always_comb begin
    if (b.le) begin
      key_nxt = b.key;
      age_nxt = age_t'(b.age + 1'b1);
    end else if (from_lo.le) begin
      key_nxt = ctl.key_new;
      age_nxt = '0;
    end else begin
      key_nxt = from_lo.key;
      age_nxt = age_t'(from_lo.age + 1'b1);
    end
  end

  always_comb begin
    match   = valid && (age_r == ctl.age_lim);
    old_key = match ? key_r : '0;
    mid_key = sel ? key_r : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      key_r <= key_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

>>> rtl/sliding_window_median_unit.sv
// Top level of the sliding window median unit.
`timescale 1ns / 1ps
// Running lower-median filter over the last window_size signed samples. A row of
// WINDOW_MAX cells keeps the window sorted, each entry tagged with its age; every
// accepted sample removes the oldest entry (once full) and inserts the new one in
// the same row update, each cell looking only at its two neighbors. One sample is
// accepted per clock while results are taken; a result passes from the cell row
// to the output register once that is free, and a stalled output holds the input.
// No result comes until window_size samples have arrived since reset, a config
// write, or a sample with start_req set. window_size 0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX. Write window_size only while the unit is idle.
`include "sliding_window_median_unit_macros.svh"
module sliding_window_median_unit import swm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg_wdata,
  input  logic            cfg_we,
  swm_in_if.sink          in_ch,
  swm_out_if.source       out_ch
);

  cfg_t       win_r, win_nxt;
  cnt_t       fill_r, fill_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  key_t       median_r, median_nxt;

  cnt_t       eff_w;
  age_t       age_lim;
  age_t       mid;
  logic       in_acc;
  logic       out_free;
  cnt_t       n_old;
  cnt_t       m_cnt;
  cnt_t       fill_new;
  logic       ev;
  logic       emit;
  key_t       key_old;
  key_t       mid_sel;
  cell_ctl_t  ctl;

  cell_link_t                  a_link [WINDOW_MAX+1];
  cell_link_t                  b_link [WINDOW_MAX+1];
  logic       [WINDOW_MAX-1:0] match_v;
  logic       [WINDOW_MAX-1:0] valid_v;
  logic       [WINDOW_MAX-1:0] bvalid_v;
  logic       [WINDOW_MAX-1:0] sel_v;
  key_t                        old_keys [WINDOW_MAX];
  key_t                        mid_keys [WINDOW_MAX];

  // Effective window length and median position.
  always_comb begin
    if (win_r == '0) begin
      eff_w = cnt_t'(1);
    end else if (32'(win_r) > 32'(WINDOW_MAX)) begin
      eff_w = cnt_t'(WINDOW_MAX);
    end else begin
      eff_w = cnt_t'(win_r);
    end
    age_lim = age_t'(eff_w - 1'b1);
    if (eff_w[0]) begin
      mid = age_t'(eff_w >> 1);
    end else begin
      mid = age_t'((eff_w >> 1) - 1'b1);
    end
  end

  // Handshake and window bookkeeping.
  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    in_ch.ready = !pend_r || out_free;
    in_acc      = in_ch.valid && in_ch.ready;
    n_old       = in_ch.start_req ? '0 : fill_r;
    ev          = (n_old >= eff_w);
    m_cnt       = ev ? cnt_t'(eff_w - 1'b1) : n_old;
    fill_new    = cnt_t'(m_cnt + 1'b1);
    emit        = (fill_new == eff_w);
  end

  always_comb begin
    key_old = '0;
    mid_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      key_old = key_old | old_keys[i];
      mid_sel = mid_sel | mid_keys[i];
    end
  end

  always_comb begin
    ctl.upd     = in_acc;
    ctl.ev      = ev;
    ctl.key_new = key_t'(in_ch.sample) ^ SIGN_FLIP;
    ctl.key_old = key_old;
    ctl.age_lim = age_lim;
  end

  assign a_link[WINDOW_MAX] = '0;
  assign b_link[0]          = '{key: '0, age: '0, le: 1'b1};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign valid_v[i]  = (cnt_t'(i) < n_old);
    assign bvalid_v[i] = (cnt_t'(i) < m_cnt);
    assign sel_v[i]    = (age_t'(i) == mid);

    swm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .valid   (valid_v[i]),
      .bvalid  (bvalid_v[i]),
      .sel     (sel_v[i]),
      .from_hi (a_link[i+1]),
      .from_lo (b_link[i]),
      .to_lo   (a_link[i]),
      .to_hi   (b_link[i+1]),
      .match   (match_v[i]),
      .old_key (old_keys[i]),
      .mid_key (mid_keys[i])
    );
  end

  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    median_nxt    = median_r;
    // Pending median moves from the cell row to the output register.
    if (pend_r && out_free) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      median_nxt    = mid_sel ^ SIGN_FLIP;
    end
    if (in_acc) begin
      fill_nxt = fill_new;
      pend_nxt = emit;
    end
    if (cfg_we) begin
      win_nxt  = cfg_wdata;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= cfg_t'(3);
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = $signed(median_r);

  `SWM_ASSERT_IMPL(a_fill_in_window, 1'b1, fill_r <= eff_w)
  `SWM_ASSERT_IMPL(a_one_oldest, in_acc && ev, $onehot(match_v))
  `SWM_ASSERT_NEXT(a_emit_pends, in_acc && emit && !cfg_we, pend_r)
  `SWM_ASSERT_NEXT(a_cfg_empties, cfg_we, fill_r == '0)

endmodule
